FILE: design/ett_pkg.sv
// ett_pkg: shared types and constants for the link metric block
// no dependencies
package ett_pkg;

  localparam int unsigned RateW   = 8;
  localparam int unsigned ClampW  = 7;
  localparam int unsigned ProdW   = 14;
  localparam int unsigned DelayW  = 24;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned NumW    = 40;
  localparam int unsigned EtxW    = 20;
  localparam int unsigned MetricW = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned InW     = 64;
  localparam int unsigned OutW    = 48;

  localparam logic [ClampW-1:0]  RateCap     = 7'd100;
  localparam logic [NumW-1:0]    EtxNum      = 40'd1000000;
  localparam logic [DelayW-1:0]  DelayOffset = 24'd100;
  localparam logic [MetricW-1:0] ByteLimit   = 32'd2550;
  localparam logic [SizeW-1:0]   AvgReset    = 16'd1024;
  localparam logic [12:0]        TenthRecip  = 13'd6554;
  localparam logic [ByteW-1:0]   ByteBad     = 8'hff;

  // one word in flight through the divider row
  typedef struct packed {
    logic             good;
    logic [ProdW-1:0] den_e;
    logic [ProdW-1:0] rem_e;
    logic [NumW-1:0]  num_e;
    logic [SizeW-1:0] den_t;
    logic [SizeW-1:0] rem_t;
    logic [NumW-1:0]  num_t;
  } lane_t;

endpackage

FILE: design/ett_cell.sv
// ett_cell: one restoring division step for both quotients
// depends on ett_pkg
module ett_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ett_pkg::lane_t lane_i,
  output logic          valid_o,
  output ett_pkg::lane_t lane_o
);

  logic           valid_q;
  ett_pkg::lane_t lane_q, lane_d;
  logic [ett_pkg::ProdW:0] trial_e;
  logic [ett_pkg::SizeW:0] trial_t;

  always_comb begin
    lane_d  = lane_i;
    trial_e = {lane_i.rem_e, lane_i.num_e[ett_pkg::NumW-1]};
    trial_t = {lane_i.rem_t, lane_i.num_t[ett_pkg::NumW-1]};
    if (trial_e >= {1'b0, lane_i.den_e}) begin
      lane_d.rem_e = ett_pkg::ProdW'(trial_e - {1'b0, lane_i.den_e});
      lane_d.num_e = {lane_i.num_e[ett_pkg::NumW-2:0], 1'b1};
    end else begin
      lane_d.rem_e = trial_e[ett_pkg::ProdW-1:0];
      lane_d.num_e = {lane_i.num_e[ett_pkg::NumW-2:0], 1'b0};
    end
    if (trial_t >= {1'b0, lane_i.den_t}) begin
      lane_d.rem_t = ett_pkg::SizeW'(trial_t - {1'b0, lane_i.den_t});
      lane_d.num_t = {lane_i.num_t[ett_pkg::NumW-2:0], 1'b1};
    end else begin
      lane_d.rem_t = trial_t[ett_pkg::SizeW-1:0];
      lane_d.num_t = {lane_i.num_t[ett_pkg::NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

FILE: design/ett_link_metric.sv
// ett_link_metric: expected transmission time link metric, top level
// depends on ett_pkg and ett_cell
//
// Accepts one link record per cycle while no result is held back and returns one
// result per record through one input stage, a row of 40 division cells that each retire one
// quotient bit of both divisions, a product stage and an output stage. The
// whole pipeline advances together and holds while a result is not taken.
module ett_link_metric (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // fwd_valid, fwd_rate, rev_valid, rev_rate, probe_delay, probe_size
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // metric, metric_good, metric_byte
  output logic [47:0] m_axis_tdata_o
);

  localparam int unsigned Cells = ett_pkg::NumW;

  logic [ett_pkg::SizeW-1:0] avg_q;
  logic adv;

  logic                       fwd_valid, rev_valid;
  logic [ett_pkg::RateW-1:0]  fwd_rate, rev_rate;
  logic [ett_pkg::DelayW-1:0] probe_delay;
  logic [ett_pkg::SizeW-1:0]  probe_size;
  logic [ett_pkg::ClampW-1:0] fr, rr;
  ett_pkg::lane_t             in_lane;

  ett_pkg::lane_t lanes [0:Cells];
  logic           valids [0:Cells];

  logic        a_valid_q, a_good_q, a_hi_q;
  logic [51:0] a_prod_q;

  logic                       o_valid_q, o_good_q;
  logic [ett_pkg::MetricW-1:0] o_metric_q, metric_d;
  logic [ett_pkg::ByteW-1:0]  o_byte_q, byte_d;
  logic [24:0]                tenth;

  assign cfg_ready_o     = 1'b1;
  assign adv             = !o_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= ett_pkg::AvgReset;
    end else if (cfg_valid_i) begin
      avg_q <= cfg_data_i;
    end
  end

  assign fwd_valid   = s_axis_tdata_i[0];
  assign fwd_rate    = s_axis_tdata_i[8:1];
  assign rev_valid   = s_axis_tdata_i[9];
  assign rev_rate    = s_axis_tdata_i[17:10];
  assign probe_delay = s_axis_tdata_i[41:18];
  assign probe_size  = s_axis_tdata_i[57:42];

  always_comb begin
    fr = (fwd_rate > {1'b0, ett_pkg::RateCap}) ? ett_pkg::RateCap : fwd_rate[6:0];
    rr = (rev_rate > {1'b0, ett_pkg::RateCap}) ? ett_pkg::RateCap : rev_rate[6:0];
    in_lane.good  = fwd_valid && rev_valid && (fr != '0) && (rr != '0) &&
                    (probe_delay > ett_pkg::DelayOffset) && (probe_size != '0);
    in_lane.den_e = fr * rr;
    in_lane.rem_e = '0;
    in_lane.num_e = ett_pkg::EtxNum;
    in_lane.den_t = probe_size;
    in_lane.rem_t = '0;
    in_lane.num_t = ett_pkg::NumW'(avg_q) *
                    ett_pkg::NumW'(probe_delay - ett_pkg::DelayOffset);
  end

  // input stage
  logic           v0_q;
  ett_pkg::lane_t l0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l0_q <= in_lane;
    end
  end

  assign lanes[0]  = l0_q;
  assign valids[0] = v0_q;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    ett_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (valids[i]),
      .lane_i  (lanes[i]),
      .valid_o (valids[i+1]),
      .lane_o  (lanes[i+1])
    );
  end

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= valids[Cells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_good_q <= lanes[Cells].good;
      a_hi_q   <= |lanes[Cells].num_t[39:32];
      a_prod_q <= 52'(lanes[Cells].num_e[ett_pkg::EtxW-1:0]) *
                  52'(lanes[Cells].num_t[31:0]);
    end
  end

  // saturate and scale
  always_comb begin
    if (!a_good_q) begin
      metric_d = '0;
    end else if (a_hi_q || (a_prod_q[51:32] != '0)) begin
      metric_d = '1;
    end else begin
      metric_d = a_prod_q[31:0];
    end
    tenth = metric_d[11:0] * ett_pkg::TenthRecip;
    if (!a_good_q || (metric_d > ett_pkg::ByteLimit)) begin
      byte_d = ett_pkg::ByteBad;
    end else begin
      byte_d = tenth[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (adv) begin
      o_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_good_q   <= a_good_q;
      o_metric_q <= metric_d;
      o_byte_q   <= byte_d;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {7'b0, o_byte_q, o_good_q, o_metric_q};

endmodule

FILE: design/ett_checker.sv
// ett_checker: port-level assertions for ett_link_metric, bound to the top
// depends on ett_link_metric ports only
module ett_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // bad metric reads as zero with byte 255
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[32] |->
      (m_axis_tdata_o[31:0] == 32'd0) && (m_axis_tdata_o[40:33] == 8'hff))
    else $error("bad metric not cleared");

  // large metric saturates the byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[31:0] > 32'd2550) |->
      (m_axis_tdata_o[40:33] == 8'hff))
    else $error("byte scaling not saturated");

  // input side only stalls behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

endmodule

bind ett_link_metric ett_checker u_ett_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

FILE: verif/tb_ett_link_metric.sv
// tb_ett_link_metric: self-checking testbench for the link metric block
// drives link records through a directed table and random traffic with random gaps
// depends on ett_pkg and the ett_link_metric design
module tb_ett_link_metric;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                       fwd_valid;
    logic [ett_pkg::RateW-1:0]  fwd_rate;
    logic                       rev_valid;
    logic [ett_pkg::RateW-1:0]  rev_rate;
    logic [ett_pkg::DelayW-1:0] probe_delay;
    logic [ett_pkg::SizeW-1:0]  probe_size;
  } link_rec_t;

  typedef struct packed {
    logic [ett_pkg::MetricW-1:0] metric;
    logic                        good;
    logic [ett_pkg::ByteW-1:0]   mbyte;
  } metric_res_t;

  typedef struct {
    link_rec_t   rec;
    logic        known;
    metric_res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;

  metric_res_t expected_q[$];
  logic [15:0] avg_size;
  int errors = 0;
  int n_words = 0;
  int n_good = 0;
  int n_sat = 0;
  bit sending_done = 0;

  always #5 clk_i = ~clk_i;

  ett_link_metric u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  function automatic logic [63:0] pack_rec(link_rec_t r);
    return {6'd0, r.probe_size, r.probe_delay, r.rev_rate, r.rev_valid,
            r.fwd_rate, r.fwd_valid};
  endfunction

  function automatic metric_res_t etx_metric(link_rec_t r, logic [15:0] avg);
    logic [7:0] fr, rr;
    logic [63:0] etx, t, prod;
    metric_res_t res;
    fr = (r.fwd_rate > 8'd100) ? 8'd100 : r.fwd_rate;
    rr = (r.rev_rate > 8'd100) ? 8'd100 : r.rev_rate;
    res = '0;
    res.good = r.fwd_valid && r.rev_valid && fr != 0 && rr != 0 &&
               r.probe_delay > 24'd100 && r.probe_size != 0;
    if (res.good) begin
      etx = 64'd1000000 / (64'(fr) * 64'(rr));
      t = (64'(avg) * (64'(r.probe_delay) - 64'd100)) / 64'(r.probe_size);
      prod = etx * t;
      res.metric = (prod > 64'hffff_ffff) ? 32'hffff_ffff : prod[31:0];
    end
    if (!res.good || res.metric > 32'd2550) res.mbyte = 8'hff;
    else res.mbyte = 8'(res.metric / 10);
    return res;
  endfunction

  task automatic write_avg(logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    avg_size = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_rec(link_rec_t r, logic known, metric_res_t res);
    int gap;
    metric_res_t pred;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pack_rec(r);
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = etx_metric(r, avg_size);
    if (known && pred !== res) begin
      $error("table row mismatch: metric exp %0d got %0d", res.metric, pred.metric);
      errors++;
    end
    expected_q.push_back(known ? res : pred);
    @(negedge clk_i);
  endtask

  function automatic link_rec_t rand_rec();
    link_rec_t r;
    r = '0;
    r.fwd_valid = ($urandom_range(0, 15) != 0);
    r.rev_valid = ($urandom_range(0, 15) != 0);
    r.fwd_rate = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 100));
    r.rev_rate = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 100));
    case ($urandom_range(0, 3))
      0: r.probe_delay = 24'($urandom);
      1: r.probe_delay = 24'($urandom_range(90, 300));
      default: r.probe_delay = 24'($urandom_range(101, 20000));
    endcase
    case ($urandom_range(0, 3))
      0: r.probe_size = 16'($urandom);
      1: r.probe_size = 16'($urandom_range(0, 4));
      default: r.probe_size = 16'($urandom_range(500, 20000));
    endcase
    return r;
  endfunction

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // receiver with random stalls
  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    metric_res_t act, exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      act.metric = m_axis_tdata_o[31:0];
      act.good   = m_axis_tdata_o[32];
      act.mbyte  = m_axis_tdata_o[40:33];
      if (expected_q.size() == 0) begin
        $error("result word with no expectation");
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        n_words++;
        if (act.good) n_good++;
        if (act.metric == 32'hffff_ffff) n_sat++;
        if (act.metric !== exp_res.metric) begin
          $error("metric exp %0d got %0d", exp_res.metric, act.metric);
          errors++;
        end
        if (act.good !== exp_res.good) begin
          $error("metric_good exp %0d got %0d", exp_res.good, act.good);
          errors++;
        end
        if (act.mbyte !== exp_res.mbyte) begin
          $error("metric_byte exp %0d got %0d", exp_res.mbyte, act.mbyte);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t table_rows[$];
    metric_res_t bad;
    link_rec_t r;
    logic [15:0] avg_list[6];
    bad = '{metric: '0, good: 1'b0, mbyte: 8'hff};
    avg_list = '{16'd1, 16'd65535, 16'd0, 16'd1500, 16'd7, 16'd1024};
    // missing flags, zero rates, short delay, zero size
    table_rows.push_back('{'{1'b0, 8'd100, 1'b1, 8'd100, 24'd1000, 16'd100}, 1'b1, bad});
    table_rows.push_back('{'{1'b1, 8'd100, 1'b0, 8'd100, 24'd1000, 16'd100}, 1'b1, bad});
    table_rows.push_back('{'{1'b1, 8'd0, 1'b1, 8'd100, 24'd1000, 16'd100}, 1'b1, bad});
    table_rows.push_back('{'{1'b1, 8'd100, 1'b1, 8'd0, 24'd1000, 16'd100}, 1'b1, bad});
    table_rows.push_back('{'{1'b1, 8'd100, 1'b1, 8'd100, 24'd100, 16'd100}, 1'b1, bad});
    table_rows.push_back('{'{1'b1, 8'd100, 1'b1, 8'd100, 24'd0, 16'd100}, 1'b1, bad});
    table_rows.push_back('{'{1'b1, 8'd100, 1'b1, 8'd100, 24'd1000, 16'd0}, 1'b1, bad});
    // reset avg 1024: etx 100, t = 1024*900/1024 = 900 -> 90000
    table_rows.push_back('{'{1'b1, 8'd100, 1'b1, 8'd100, 24'd1000, 16'd1024}, 1'b1,
                           '{32'd90000, 1'b1, 8'hff}});
    // clamp above 100: etx 100, t = 1 -> 100, byte 10
    table_rows.push_back('{'{1'b1, 8'd255, 1'b1, 8'd200, 24'd101, 16'd1024}, 1'b1,
                           '{32'd100, 1'b1, 8'd10}});
    // saturation: etx 1000000 times a huge t
    table_rows.push_back('{'{1'b1, 8'd1, 1'b1, 8'd1, 24'hffffff, 16'd1}, 1'b1,
                           '{32'hffff_ffff, 1'b1, 8'hff}});
    table_rows.push_back('{'{1'b1, 8'd1, 1'b1, 8'd255, 24'hffffff, 16'hffff}, 1'b0, bad});
    table_rows.push_back('{'{1'b1, 8'd50, 1'b1, 8'd99, 24'd5000, 16'd1500}, 1'b0, bad});
    table_rows.push_back('{'{1'b1, 8'd100, 1'b1, 8'd100, 24'd300, 16'd8000}, 1'b0, bad});

    avg_size = 16'd1024;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (table_rows[i]) send_rec(table_rows[i].rec, table_rows[i].known, table_rows[i].res);
    drain();
    foreach (avg_list[p]) begin
      write_avg(avg_list[p]);
      repeat (316) begin
        r = rand_rec();
        send_rec(r, 1'b0, bad);
      end
      drain();
    end
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    $display("checked %0d result words, %0d good, %0d saturated", n_words, n_good, n_sat);
    $display("directed edge rows, then random records under six packet size settings");
    if (errors == 0 && expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
